@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted (active low)
`define CC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds through reset
`define CC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/cc_hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// cc_hsv_pkg
// Types, constants and the divide-by-255 helper for the HSV composer pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc_hsv_pkg;

    // Full-scale values of an 8-bit channel and of its square
    localparam logic [7:0]  FULL8  = 8'd255;
    localparam logic [15:0] FULL16 = 16'd65025;

    // 2^24 / 255 rounded down: reciprocal used for division by 255
    localparam logic [16:0] RECIP_255 = 17'd65793;

    // Hue sectors
    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    // Configuration register indexes
    localparam logic REG_COMPOSE_MODE = 1'b0;

    // After hue split
    typedef struct packed {
        logic       mode;
        logic       gray;
        logic [2:0] sector;
        logic [7:0] rem;
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;
    } split_t;

    // After the 8x8 products
    typedef struct packed {
        logic        mode;
        logic        gray;
        logic [2:0]  sector;
        logic [7:0]  h;
        logic [7:0]  s;
        logic [7:0]  v;
        logic [15:0] sr;
        logic [15:0] snr;
        logic [15:0] pv;
    } prod_t;

    // After the value products
    typedef struct packed {
        logic        mode;
        logic        gray;
        logic [2:0]  sector;
        logic [7:0]  h;
        logic [7:0]  s;
        logic [7:0]  v;
        logic [7:0]  p;
        logic [23:0] qn;
        logic [23:0] tn;
    } scale_t;

    // After the first division by 255 of q and t
    typedef struct packed {
        logic        mode;
        logic        gray;
        logic [2:0]  sector;
        logic [7:0]  h;
        logic [7:0]  s;
        logic [7:0]  v;
        logic [7:0]  p;
        logic [15:0] q1;
        logic [15:0] t1;
    } part_t;

    // Composed pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // floor(x / 255) for x below 255 * 65536: reciprocal multiply, then one
    // compare-and-correct since the estimate is low by at most one
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [40:0] prod;
        logic [16:0] quo;
        logic [24:0] back;
        logic [24:0] rest;
        prod = {17'b0, x} * {24'b0, RECIP_255};
        quo  = prod[40:24];
        back = {8'b0, quo} * 25'd255;
        rest = {1'b0, x} - back;
        if (rest >= 25'd255) begin
            quo = quo + 17'd1;
        end
        return quo[15:0];
    endfunction

endpackage

@@ rtl/core/channel_compose_hsv_to_rgb.sv @@
// ----------------------------------------------------------------------------
// channel_compose_hsv_to_rgb
// Pixel composer: RGB pass-through or 8-bit HSV to RGB, with an APB register.
// ----------------------------------------------------------------------------
// One pixel enters per clock while back-pressure has not filled it; the
// pipeline is five register stages (hue split, 8x8 products, value products,
// then two reciprocal divide-by-255 stages with sector select), each with a
// valid bit, so a back-pressured output stalls the stream without loss and
// bubbles are squeezed out. compose_mode lives at byte address 0; write it
// only while no pixel is in flight.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module channel_compose_hsv_to_rgb (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_chan_one,
    input  logic [7:0]  s_chan_two,
    input  logic [7:0]  s_chan_three,
    // composed pixels
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out
);

    logic                 mode_reg;
    logic                 mode_next;
    logic                 reg_write;
    logic                 front_valid;
    logic                 front_ready;
    cc_hsv_pkg::prod_t    front_data;
    logic                 scale_valid;
    logic                 scale_ready;
    cc_hsv_pkg::part_t    scale_data;
    cc_hsv_pkg::rgb_t     rgb_data;

    // Register port
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite
                    && (paddr[2] == cc_hsv_pkg::REG_COMPOSE_MODE);
    assign mode_next = reg_write ? pwdata[0] : mode_reg;
    assign prdata    = (paddr[2] == cc_hsv_pkg::REG_COMPOSE_MODE)
                     ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // Pipeline
    cc_hsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_h      (s_chan_one),
        .in_s      (s_chan_two),
        .in_v      (s_chan_three),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    cc_hsv_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    cc_hsv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (rgb_data)
    );

    assign m_red_out   = rgb_data.red;
    assign m_green_out = rgb_data.green;
    assign m_blue_out  = rgb_data.blue;

    // With the output register empty nothing upstream can be blocked
    `CC_ASSERT(a_ready_when_drained, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output")

endmodule

@@ rtl/core/cc_hsv_front.sv @@
// ----------------------------------------------------------------------------
// cc_hsv_front
// Stages 1-2: hue split into sector and remainder, then the 8x8 products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cc_hsv_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mode,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_h,
    input  logic [7:0]           in_s,
    input  logic [7:0]           in_v,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cc_hsv_pkg::prod_t    out_data
);

    logic                  split_valid_reg;
    logic                  split_ready;
    cc_hsv_pkg::split_t    split_reg;
    cc_hsv_pkg::split_t    split_next;
    logic                  prod_valid_reg;
    logic                  prod_ready;
    cc_hsv_pkg::prod_t     prod_reg;
    cc_hsv_pkg::prod_t     prod_next;
    logic [10:0]           h6;
    logic [2:0]            sector;
    logic [10:0]           h6_rem;

    assign prod_ready  = !prod_valid_reg || out_ready;
    assign split_ready = !split_valid_reg || prod_ready;
    assign in_ready    = split_ready;

    // Stage 1: h*6 split by 255; the full-circle hue wraps to sector 0
    always_comb begin
        h6 = {1'b0, in_h, 2'b0} + {2'b0, in_h, 1'b0};
        if (h6 >= 11'd1530) begin
            sector = cc_hsv_pkg::SECTOR_0;
        end else if (h6 >= 11'd1275) begin
            sector = cc_hsv_pkg::SECTOR_5;
        end else if (h6 >= 11'd1020) begin
            sector = cc_hsv_pkg::SECTOR_4;
        end else if (h6 >= 11'd765) begin
            sector = cc_hsv_pkg::SECTOR_3;
        end else if (h6 >= 11'd510) begin
            sector = cc_hsv_pkg::SECTOR_2;
        end else if (h6 >= 11'd255) begin
            sector = cc_hsv_pkg::SECTOR_1;
        end else begin
            sector = cc_hsv_pkg::SECTOR_0;
        end
        if (h6 >= 11'd1530) begin
            h6_rem = 11'd0;
        end else begin
            h6_rem = h6 - ({8'b0, sector} * 11'd255);
        end
        split_next.mode   = mode;
        split_next.gray   = (in_s == 8'd0);
        split_next.sector = sector;
        split_next.rem    = h6_rem[7:0];
        split_next.h      = in_h;
        split_next.s      = in_s;
        split_next.v      = in_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_valid_reg <= 1'b0;
        end else if (split_ready) begin
            split_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (split_ready && in_valid) begin
            split_reg <= split_next;
        end
    end

    // Stage 2: s*f, s*(1-f) and v*(1-s), all scaled by 255
    always_comb begin
        prod_next.mode   = split_reg.mode;
        prod_next.gray   = split_reg.gray;
        prod_next.sector = split_reg.sector;
        prod_next.h      = split_reg.h;
        prod_next.s      = split_reg.s;
        prod_next.v      = split_reg.v;
        prod_next.sr     = {8'b0, split_reg.s} * {8'b0, split_reg.rem};
        prod_next.snr    = {8'b0, split_reg.s}
                         * {8'b0, cc_hsv_pkg::FULL8 - split_reg.rem};
        prod_next.pv     = {8'b0, split_reg.v}
                         * {8'b0, cc_hsv_pkg::FULL8 - split_reg.s};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= split_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && split_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_data  = prod_reg;

    // Sector and remainder stay in range
    `CC_ASSERT(a_sector_range, aclk, aresetn, split_valid_reg |-> (split_reg.sector <= cc_hsv_pkg::SECTOR_5 && split_reg.rem != 8'd255), "hue split out of range")
    // A stalled stage-1 request is kept
    `CC_ASSERT(a_split_hold, aclk, aresetn, (split_valid_reg && !prod_ready) |=> (split_valid_reg && $stable(split_reg)), "stage 1 lost a stalled request")

endmodule

@@ rtl/core/cc_hsv_scale.sv @@
// ----------------------------------------------------------------------------
// cc_hsv_scale
// Stages 3-4: value products for q and t, p, and first division by 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cc_hsv_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cc_hsv_pkg::prod_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cc_hsv_pkg::part_t    out_data
);

    logic                  scale_valid_reg;
    logic                  scale_ready;
    cc_hsv_pkg::scale_t    scale_reg;
    cc_hsv_pkg::scale_t    scale_next;
    logic                  part_valid_reg;
    logic                  part_ready;
    cc_hsv_pkg::part_t     part_reg;
    cc_hsv_pkg::part_t     part_next;
    logic [15:0]           p_wide;

    assign part_ready  = !part_valid_reg || out_ready;
    assign scale_ready = !scale_valid_reg || part_ready;
    assign in_ready    = scale_ready;

    // Stage 3: v*(65025 - s*f) and v*(65025 - s*(1-f)); p = pv / 255
    always_comb begin
        p_wide = cc_hsv_pkg::div255({8'b0, in_data.pv});
        scale_next.mode   = in_data.mode;
        scale_next.gray   = in_data.gray;
        scale_next.sector = in_data.sector;
        scale_next.h      = in_data.h;
        scale_next.s      = in_data.s;
        scale_next.v      = in_data.v;
        scale_next.p      = p_wide[7:0];
        scale_next.qn     = {16'b0, in_data.v}
                          * {8'b0, cc_hsv_pkg::FULL16 - in_data.sr};
        scale_next.tn     = {16'b0, in_data.v}
                          * {8'b0, cc_hsv_pkg::FULL16 - in_data.snr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_valid_reg <= 1'b0;
        end else if (scale_ready) begin
            scale_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (scale_ready && in_valid) begin
            scale_reg <= scale_next;
        end
    end

    // Stage 4: first of two divisions by 255 (65025 = 255 * 255)
    always_comb begin
        part_next.mode   = scale_reg.mode;
        part_next.gray   = scale_reg.gray;
        part_next.sector = scale_reg.sector;
        part_next.h      = scale_reg.h;
        part_next.s      = scale_reg.s;
        part_next.v      = scale_reg.v;
        part_next.p      = scale_reg.p;
        part_next.q1     = cc_hsv_pkg::div255(scale_reg.qn);
        part_next.t1     = cc_hsv_pkg::div255(scale_reg.tn);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_valid_reg <= 1'b0;
        end else if (part_ready) begin
            part_valid_reg <= scale_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (part_ready && scale_valid_reg) begin
            part_reg <= part_next;
        end
    end

    assign out_valid = part_valid_reg;
    assign out_data  = part_reg;

    // p never exceeds the value it was scaled from
    `CC_ASSERT(a_p_bound, aclk, aresetn, scale_valid_reg |-> (scale_reg.p <= scale_reg.v), "p above value")

endmodule

@@ rtl/core/cc_hsv_back.sv @@
// ----------------------------------------------------------------------------
// cc_hsv_back
// Stage 5: second division by 255, sector select and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cc_hsv_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cc_hsv_pkg::part_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cc_hsv_pkg::rgb_t     out_data
);

    logic                 rgb_valid_reg;
    logic                 rgb_ready;
    cc_hsv_pkg::rgb_t     rgb_reg;
    cc_hsv_pkg::rgb_t     rgb_next;
    logic [15:0]          q_wide;
    logic [15:0]          t_wide;
    logic [7:0]           q;
    logic [7:0]           t;

    assign rgb_ready = !rgb_valid_reg || out_ready;
    assign in_ready  = rgb_ready;

    // Finish q and t, then pick the components
    always_comb begin
        q_wide = cc_hsv_pkg::div255({8'b0, in_data.q1});
        t_wide = cc_hsv_pkg::div255({8'b0, in_data.t1});
        q      = q_wide[7:0];
        t      = t_wide[7:0];
        if (!in_data.mode) begin
            rgb_next = '{red: in_data.h, green: in_data.s, blue: in_data.v};
        end else if (in_data.gray) begin
            rgb_next = '{red: in_data.v, green: in_data.v, blue: in_data.v};
        end else begin
            case (in_data.sector)
                cc_hsv_pkg::SECTOR_0: begin
                    rgb_next = '{red: in_data.v, green: t, blue: in_data.p};
                end
                cc_hsv_pkg::SECTOR_1: begin
                    rgb_next = '{red: q, green: in_data.v, blue: in_data.p};
                end
                cc_hsv_pkg::SECTOR_2: begin
                    rgb_next = '{red: in_data.p, green: in_data.v, blue: t};
                end
                cc_hsv_pkg::SECTOR_3: begin
                    rgb_next = '{red: in_data.p, green: q, blue: in_data.v};
                end
                cc_hsv_pkg::SECTOR_4: begin
                    rgb_next = '{red: t, green: in_data.p, blue: in_data.v};
                end
                default: begin
                    rgb_next = '{red: in_data.v, green: in_data.p, blue: q};
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rgb_valid_reg <= 1'b0;
        end else if (rgb_ready) begin
            rgb_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rgb_ready && in_valid) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = rgb_valid_reg;
    assign out_data  = rgb_reg;

    // A request taken into the output register shows up next cycle
    `CC_ASSERT(a_out_load, aclk, aresetn, (in_valid && in_ready) |=> out_valid, "output register missed a request")

endmodule
